### rtl/pls_pkg.sv
// Shared types and constants of the positional list store.
// No dependencies; compiled first.
package pls_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_REVERSE = 2'd2,
        OP_READ    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_last;
    } dp_stat_t;

endpackage

### rtl/pls_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on pls_pkg.
interface pls_req_if
    import pls_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pls_rsp_if
    import pls_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [VAL_W-1:0] element;
    logic                    last;
    logic [CNT_W-1:0]        length;

    modport source (output valid, output status, output element, output last, output length,
                    input ready);
    modport sink   (input valid, input status, input element, input last, input length,
                    output ready);
endinterface

### rtl/pls_ctrl.sv
// Sequencing controller: accept, execute, deliver result words.
// Depends on pls_pkg.
module pls_ctrl
    import pls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     rsp_ready,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd,
    output logic     req_ready,
    output logic     rsp_valid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp_ready && dp_stat.out_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        rsp_valid      = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.exec    = 1'b0;
        dp_cmd.step    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready      = 1'b1;
                dp_cmd.capture = req_valid;
            end
            ST_EXEC:
            begin
                dp_cmd.exec = 1'b1;
            end
            ST_OUT:
            begin
                rsp_valid   = 1'b1;
                // advance to the next element of a read-out
                dp_cmd.step = rsp_ready && !dp_stat.out_last;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/pls_dp.sv
// Datapath: cell file, length and orientation, operation logic, result register.
// Depends on pls_pkg.
module pls_dp
    import pls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 dp_cmd,
    input  logic [1:0]              req_op,
    input  logic [POS_W-1:0]        req_position,
    input  logic signed [VAL_W-1:0] req_value,
    output dp_stat_t                dp_stat,
    output logic [1:0]              rsp_status,
    output logic signed [VAL_W-1:0] rsp_element,
    output logic                    rsp_last,
    output logic [CNT_W-1:0]        rsp_length
);

    // captured request
    op_t              op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;

    // list state; rev_reg means logical element j sits at physical count-1-j
    logic [VAL_W-1:0] cells_reg  [DEPTH];
    logic [VAL_W-1:0] cells_next [DEPTH];
    logic [VAL_W-1:0] cell_below [DEPTH];
    logic [VAL_W-1:0] cell_above [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rev_reg;
    logic             rev_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // result register
    stat_t            st_reg;
    stat_t            st_next;
    logic [VAL_W-1:0] elem_reg;
    logic [VAL_W-1:0] elem_next;
    logic             last_reg;
    logic             last_next;
    logic [CNT_W-1:0] len_reg;
    logic [CNT_W-1:0] len_next;

    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] ins_q;
    logic [CNT_W-1:0] del_q;
    logic [CNT_W-1:0] step_phys;
    logic [CNT_W-1:0] rd_phys;
    logic [IDX_W-1:0] step_idx;
    logic [VAL_W-1:0] cell_rd;
    logic             ins_ok;
    logic             del_ok;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_nbr
            if (g == 0)
            begin : g_first
                assign cell_below[g] = cells_reg[g];
            end
            else
            begin : g_rest
                assign cell_below[g] = cells_reg[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_top
                assign cell_above[g] = cells_reg[g];
            end
            else
            begin : g_mid
                assign cell_above[g] = cells_reg[g+1];
            end
        end
    endgenerate

    assign k        = pos_reg - CNT_W'(1);
    assign ins_q    = rev_reg ? (count_reg - k) : k;
    assign del_q    = rev_reg ? (count_reg - CNT_W'(1) - k) : k;
    assign step_idx = idx_reg + IDX_W'(1);
    assign step_phys = rev_reg ? (count_reg - CNT_W'(1) - CNT_W'(step_idx))
                               : CNT_W'(step_idx);

    // single read port of the cell file
    always_comb
    begin
        if (dp_cmd.step)
        begin
            rd_phys = step_phys;
        end
        else if (op_reg == OP_DELETE)
        begin
            rd_phys = del_q;
        end
        else
        begin
            rd_phys = rev_reg ? (count_reg - CNT_W'(1)) : '0;
        end
    end

    assign cell_rd = cells_reg[rd_phys[IDX_W-1:0]];

    assign ins_ok = (pos_reg != '0)
                    && ({1'b0, pos_reg} <= ({1'b0, count_reg} + (CNT_W+1)'(1)))
                    && (count_reg != CNT_W'(DEPTH));
    assign del_ok = (count_reg != '0) && (pos_reg != '0) && (pos_reg <= count_reg);

    always_comb
    begin
        st_next    = st_reg;
        elem_next  = elem_reg;
        last_next  = last_reg;
        len_next   = len_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
        end

        if (dp_cmd.exec)
        begin
            st_next   = STAT_OK;
            elem_next = '0;
            last_next = 1'b1;
            idx_next  = '0;
            case (op_reg)
                OP_INSERT:
                begin
                    if ((pos_reg == '0)
                        || ({1'b0, pos_reg} > ({1'b0, count_reg} + (CNT_W+1)'(1))))
                    begin
                        st_next = STAT_RANGE;
                    end
                    else if (!ins_ok)
                    begin
                        st_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CNT_W'(i) > ins_q)
                            begin
                                cells_next[i] = cell_below[i];
                            end
                            else if (CNT_W'(i) == ins_q)
                            begin
                                cells_next[i] = val_reg;
                            end
                        end
                    end
                end
                OP_DELETE:
                begin
                    if (count_reg == '0)
                    begin
                        st_next = STAT_EMPTY;
                    end
                    else if (!del_ok)
                    begin
                        st_next = STAT_RANGE;
                    end
                    else
                    begin
                        elem_next  = cell_rd;
                        count_next = count_reg - CNT_W'(1);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (CNT_W'(i) >= del_q)
                            begin
                                cells_next[i] = cell_above[i];
                            end
                        end
                    end
                end
                OP_REVERSE:
                begin
                    if (count_reg == '0)
                    begin
                        st_next = STAT_EMPTY;
                    end
                    else
                    begin
                        rev_next = !rev_reg;
                    end
                end
                OP_READ:
                begin
                    if (count_reg == '0)
                    begin
                        st_next = STAT_EMPTY;
                    end
                    else
                    begin
                        elem_next = cell_rd;
                        last_next = (count_reg == CNT_W'(1));
                    end
                end
                default:
                begin
                    st_next = STAT_OK;
                end
            endcase
            len_next = count_next;
        end
        else if (dp_cmd.step)
        begin
            idx_next  = step_idx;
            elem_next = cell_rd;
            last_next = (CNT_W'(step_idx) == (count_reg - CNT_W'(1)));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
            last_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg  <= op_t'(req_op);
            pos_reg <= req_position;
            val_reg <= req_value;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        idx_reg  <= idx_next;
        st_reg   <= st_next;
        elem_reg <= elem_next;
        len_reg  <= len_next;
    end

    assign dp_stat.out_last = last_reg;
    assign rsp_status       = st_reg;
    assign rsp_element      = elem_reg;
    assign rsp_last         = last_reg;
    assign rsp_length       = len_reg;

endmodule

### rtl/positional_list_store_unit.sv
// Top level of the positional list store: controller plus datapath.
// Depends on pls_pkg, pls_if, pls_ctrl and pls_dp.

// The block holds an ordered list of up to 16 signed 32-bit words and takes
// one request word at a time: insert at a 1-based position, delete at a
// position (returns the removed word), reverse, or read the whole list out.
// Insert, delete, reverse and every error answer with one result word that is
// presented once the execute state that follows the accept has passed, and
// with a ready sink it is taken at once and the request side reopens.
// A read of n elements gives n result words, one per cycle while the sink is
// ready, the last flagged by last. The pace is set by the controller's
// accept/execute/deliver sequence and by the single read port of the cell
// file, which serves one element per cycle. Reverse is a flip of the
// orientation bit, not a data move, so it costs no more than an insert. A new
// request is taken only after the last result word of the previous one has
// been taken. Every result reports the length after the operation; element
// is zero except for a successful delete or a read-out.
module positional_list_store_unit
    import pls_pkg::*;
(
    input logic clk,
    input logic rst_n,
    pls_req_if.sink   req,
    pls_rsp_if.source rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequence the item: take request, execute, hand out result words
    pls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .rsp_ready (rsp.ready),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid)
    );

    // hold the list and the result register
    pls_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .req_op       (req.op),
        .req_position (req.position),
        .req_value    (req.value),
        .dp_stat      (dp_stat),
        .rsp_status   (rsp.status),
        .rsp_element  (rsp.element),
        .rsp_last     (rsp.last),
        .rsp_length   (rsp.length)
    );

    // never accept a request while a result word is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid)
        else $error("request accepted while a result word is pending");

    // the first result word follows an accepted request after the execute cycle
    a_resp_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !rsp.valid ##1 rsp.valid)
        else $error("result word not presented after execute");

    // taking the final word of an item reopens the request side
    a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
        else $error("request side not reopened after final word");

    // length never exceeds capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.length <= CNT_W'(DEPTH)))
        else $error("reported length exceeds capacity");

endmodule

### dv/tb.sv
// Self-checking testbench for positional_list_store_unit.
// Depends on rtl/pls_pkg.sv, rtl/pls_if.sv and the store RTL; needs no other file.
// Directed table first, then three random phases with varied backpressure.
module tb
    import pls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 24;    // settle time after the last result
    localparam int HOLD_CYCLES = 180;   // long receiver hold-off
    localparam int PLAN_ROWS   = 21;
    localparam int PHASE_ITEMS = 80;

    // One result word as the store should emit it.
    typedef struct {
        stat_t                   status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
        logic [CNT_W-1:0]        length;
    } rsp_word_t;

    // One row of the directed plan. Typed rows carry their own single result word
    // (element zero, last set); the others are checked against the list shadow.
    typedef struct {
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
        int                      reps;
        bit                      typed;
        stat_t                   want_status;
        logic [CNT_W-1:0]        want_len;
    } plan_row_t;

    logic clk;
    logic rst_n;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    positional_list_store_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list, front first, and its length.
    logic signed [VAL_W-1:0] shadow_cells [DEPTH];
    int                      shadow_len = 0;

    rsp_word_t fresh_results [$];    // words caused by the word just taken
    rsp_word_t pending_results [$];  // words still owed by the store, oldest first

    int err_count   = 0;
    int idle_cycles = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_ticket = 0;             // bump to ask the receiver for a long hold-off

    // Directed plan: empty-store errors, range checks, the extremes of value,
    // a fill to capacity, full-store and range errors at the top, and read-outs
    // in both orientations.
    plan_row_t plan [PLAN_ROWS] = '{
        '{OP_READ,    5'd0,  32'sd0,           1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_REVERSE, 5'd7,  32'sd0,           1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_DELETE,  5'd1,  32'sd0,           1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_DELETE,  5'd0,  32'sd0,           1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_INSERT,  5'd0,  32'sd5,           1,  1'b1, STAT_RANGE, 5'd0},
        '{OP_INSERT,  5'd2,  32'sd5,           1,  1'b1, STAT_RANGE, 5'd0},
        '{OP_INSERT,  5'd1,  32'sh7fff_ffff,   1,  1'b1, STAT_OK,    5'd1},
        '{OP_INSERT,  5'd2,  32'sh8000_0000,   1,  1'b1, STAT_OK,    5'd2},
        '{OP_DELETE,  5'd3,  32'sd0,           1,  1'b1, STAT_RANGE, 5'd2},
        '{OP_REVERSE, 5'd0,  32'sd0,           1,  1'b1, STAT_OK,    5'd2},
        '{OP_READ,    5'd31, 32'sd0,           1,  1'b0, STAT_OK,    5'd0},
        '{OP_DELETE,  5'd1,  32'sd0,           1,  1'b0, STAT_OK,    5'd0},
        '{OP_INSERT,  5'd1,  32'sh1234_0000,   15, 1'b0, STAT_OK,    5'd0},
        '{OP_INSERT,  5'd17, 32'sd9,           1,  1'b1, STAT_FULL,  5'd16},
        '{OP_INSERT,  5'd18, 32'sd9,           1,  1'b1, STAT_RANGE, 5'd16},
        '{OP_INSERT,  5'd31, 32'sd9,           1,  1'b1, STAT_RANGE, 5'd16},
        '{OP_READ,    5'd0,  32'sd0,           1,  1'b0, STAT_OK,    5'd0},
        '{OP_REVERSE, 5'd0,  32'sd0,           1,  1'b1, STAT_OK,    5'd16},
        '{OP_READ,    5'd0,  32'sd0,           1,  1'b0, STAT_OK,    5'd0},
        '{OP_DELETE,  5'd16, 32'sd0,           1,  1'b0, STAT_OK,    5'd0},
        '{OP_DELETE,  5'd17, 32'sd0,           1,  1'b1, STAT_RANGE, 5'd15}
    };

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // List shadow: apply one request word, collect the result words it causes.
    // ------------------------------------------------------------------
    function automatic void note_result(stat_t status, logic signed [VAL_W-1:0] element,
                                        logic last);
        rsp_word_t w;
        w.status  = status;
        w.element = element;
        w.last    = last;
        w.length  = shadow_len[CNT_W-1:0];
        fresh_results.push_back(w);
    endfunction

    function automatic void apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                          logic signed [VAL_W-1:0] val);
        int                      p;
        int                      lo;
        int                      hi;
        logic signed [VAL_W-1:0] gone;
        fresh_results.delete();
        p = int'(pos);
        case (op)
            OP_INSERT:
            begin
                // range check comes before the capacity check
                if (p < 1 || p > shadow_len + 1)
                    note_result(STAT_RANGE, '0, 1'b1);
                else if (shadow_len >= DEPTH)
                    note_result(STAT_FULL, '0, 1'b1);
                else
                begin
                    for (int i = shadow_len; i > p - 1; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p-1] = val;
                    shadow_len++;
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            OP_DELETE:
            begin
                // an empty store wins over a bad position
                if (shadow_len == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else if (p < 1 || p > shadow_len)
                    note_result(STAT_RANGE, '0, 1'b1);
                else
                begin
                    gone = shadow_cells[p-1];
                    for (int i = p - 1; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                    note_result(STAT_OK, gone, 1'b1);
                end
            end
            OP_REVERSE:
            begin
                if (shadow_len == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else
                begin
                    lo = 0;
                    hi = shadow_len - 1;
                    while (lo < hi)
                    begin
                        gone             = shadow_cells[lo];
                        shadow_cells[lo] = shadow_cells[hi];
                        shadow_cells[hi] = gone;
                        lo++;
                        hi--;
                    end
                    note_result(STAT_OK, '0, 1'b1);
                end
            end
            default:
            begin
                // read-out: one word per element, last on the final one
                if (shadow_len == 0)
                    note_result(STAT_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_len; i++)
                        note_result(STAT_OK, shadow_cells[i], i == shadow_len - 1);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request word and hold it until taken; then log what it owes.
    // A typed word replaces the shadow's answer but still updates the shadow.
    task automatic push_word(input op_t op, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val, input bit typed,
                             input rsp_word_t typed_want);
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        apply_list_op(op, pos, val);
        if (typed)
            pending_results.push_back(typed_want);
        else
            foreach (fresh_results[i])
                pending_results.push_back(fresh_results[i]);
    endtask

    // Idle the sender for a geometric number of cycles, or not at all.
    task automatic tx_gap();
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // Lower valid and wait until the store owes nothing more.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random words, mostly well-formed for the current length so that the list
    // actually grows, shrinks and gets read; the rest is noise on every field.
    task automatic run_random_phase(input int n_items);
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        int                      r;
        rsp_word_t               unused;
        for (int k = 0; k < n_items; k++)
        begin
            r   = $urandom_range(99);
            val = $urandom();
            pos = POS_W'($urandom_range(31));
            if (r < 15)
                op = op_t'($urandom_range(3));
            else if (r < 23)
                op = OP_REVERSE;
            else if (r < 31)
                op = OP_READ;
            else if (r < (shadow_len < 10 ? 75 : 55))
            begin
                op  = OP_INSERT;
                pos = POS_W'($urandom_range(shadow_len + 1, 1));
            end
            else if (shadow_len == 0)
            begin
                op  = OP_INSERT;
                pos = POS_W'(1);
            end
            else
            begin
                op  = OP_DELETE;
                pos = POS_W'($urandom_range(shadow_len, 1));
            end
            push_word(op, pos, val, 1'b0, unused);
            tx_gap();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rsp_word_t want;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_INSERT;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        tx_idle_pct = 38;
        rx_idle_pct = 63;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed plan; fill rows step the value so entries differ.
        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                want.status  = plan[r].want_status;
                want.element = '0;
                want.last    = 1'b1;
                want.length  = plan[r].want_len;
                push_word(plan[r].op, plan[r].pos, plan[r].value + k, plan[r].typed, want);
                tx_gap();
            end
        end

        run_random_phase(PHASE_ITEMS);

        // Hold the sender off until every owed word has come back.
        drain_results();

        tx_idle_pct = 63;
        rx_idle_pct = 38;
        run_random_phase(PHASE_ITEMS);

        // Full rate, with one long receiver hold-off up front so the store
        // backs up and stalls its request side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_ticket++;
        run_random_phase(PHASE_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: random ready, plus a long hold-off when asked.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_seen)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        $display("%0t ns: MISMATCH %s", $time, what);
        err_count++;
    endtask

    // Compare every taken result word with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        rsp_word_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result word with nothing owed");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            rsp_ch.status, want.status));
                if (rsp_ch.element !== want.element)
                    flag_mismatch($sformatf("element %0d, want %0d",
                                            rsp_ch.element, want.element));
                if (rsp_ch.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, want.last));
                if (rsp_ch.length !== want.length)
                    flag_mismatch($sformatf("length %0d, want %0d",
                                            rsp_ch.length, want.length));
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
